// ===== src/glb_pkg.sv =====
// shared types and constants of the greedy line breaker
package glb_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int LIMIT_BITS = 31;
   localparam int ADVANCE_BITS = 32;

   typedef struct packed {
      logic first;
      logic second;
   } queue_push_type;

endpackage

// ===== src/glb_result_queue.sv =====
// result queue taking up to two lines per cycle and handing out one
module glb_result_queue #(
   parameter int ENTRY_BITS = 33
) (
   input  logic                      clock,
   input  logic                      reset,
   input  glb_pkg::queue_push_type   push,
   input  logic [ENTRY_BITS-1:0]     push_data_first,
   input  logic [ENTRY_BITS-1:0]     push_data_second,
   output logic                      room,
   output logic                      out_valid,
   input  logic                      out_stall,
   output logic [ENTRY_BITS-1:0]     out_data
);
   import glb_pkg::*;

   logic [ENTRY_BITS-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0]   wr_next;
   logic                        pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   assign room      = (count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + QUEUE_PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.first) + QUEUE_PTR_BITS'(push.second);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + QUEUE_COUNT_BITS'(push.first) + QUEUE_COUNT_BITS'(push.second)
                  - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= push_data_first;
      end
      if (push.second) begin
         entry_ff[wr_next] <= push_data_second;
      end
   end

endmodule

// ===== src/greedy_line_breaker.sv =====
// Greedy first-fit line breaker: one grapheme per item in, up to two lines per item out.
// Takes one item per cycle when the result side keeps up. An item is registered on
// acceptance and resolved against the line state once the result queue has room, so
// a line passes through the input register and the result queue. An item that closes
// two lines (an overflowing break followed by a mandatory break or end of text) hands
// its two lines to the result port in turn; a four-entry result queue absorbs this and
// stalls the input only when fewer than two entries are free. Width sums saturate at
// 2^WIDTH_BITS - 1; state clears after each end of text.
module greedy_line_breaker #(
   parameter int OFFSET_BITS = 16,
   parameter int WIDTH_BITS  = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [glb_pkg::LIMIT_BITS-1:0]    csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [OFFSET_BITS-1:0]            req_grapheme_end,
   input  logic [glb_pkg::ADVANCE_BITS-1:0]  req_advance,
   input  logic                              req_break_after,
   input  logic                              req_mandatory,
   input  logic                              req_end_of_text,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [OFFSET_BITS-1:0]            rsp_line_begin,
   output logic [OFFSET_BITS-1:0]            rsp_line_finish,
   output logic                              rsp_final_line
);
   import glb_pkg::*;

   localparam int ENTRY_BITS = 2 * OFFSET_BITS + 1;

   logic [LIMIT_BITS-1:0]   limit_ff;
   logic                    in_valid_ff;
   logic [OFFSET_BITS-1:0]  pos_ff;
   logic [ADVANCE_BITS-1:0] adv_ff;
   logic                    brk_ff, mand_ff, eot_ff;

   logic [OFFSET_BITS-1:0]  open_ff, open_in;
   logic [OFFSET_BITS-1:0]  last_ff, last_in;
   logic [WIDTH_BITS-1:0]   commit_ff, commit_in;
   logic [WIDTH_BITS-1:0]   pend_ff, pend_in;

   logic                    room, advance, accept;
   logic [WIDTH_BITS:0]     pend_raw, total_raw;
   logic [WIDTH_BITS-1:0]   pend_sum, total;
   logic                    is_break, overflow, closes;
   logic [OFFSET_BITS-1:0]  open_mid, close_begin;
   logic                    close_final;
   queue_push_type          push;
   logic [ENTRY_BITS-1:0]   data_first, data_second, data_out;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pend_raw  = {1'b0, pend_ff} + {1'b0, WIDTH_BITS'(adv_ff)};
      pend_sum  = pend_raw[WIDTH_BITS] ? '1 : pend_raw[WIDTH_BITS-1:0];
      total_raw = {1'b0, commit_ff} + {1'b0, pend_sum};
      total     = total_raw[WIDTH_BITS] ? '1 : total_raw[WIDTH_BITS-1:0];
      is_break  = brk_ff || mand_ff || eot_ff;
      overflow  = is_break && (last_ff > open_ff) && (total > WIDTH_BITS'(limit_ff));
      open_mid  = overflow ? last_ff : open_ff;
      closes    = is_break && (mand_ff || eot_ff);
      close_final = eot_ff;
      if (!mand_ff && !(open_mid < pos_ff)) begin
         close_begin = pos_ff;
      end else begin
         close_begin = open_mid;
      end

      open_in   = open_ff;
      last_in   = last_ff;
      commit_in = commit_ff;
      pend_in   = pend_ff;
      if (is_break) begin
         open_in   = open_mid;
         commit_in = overflow ? pend_sum : total;
         pend_in   = '0;
         last_in   = pos_ff;
         if (mand_ff) begin
            open_in   = pos_ff;
            commit_in = '0;
         end
         if (eot_ff) begin
            open_in   = '0;
            last_in   = '0;
            commit_in = '0;
         end
      end else begin
         pend_in = pend_sum;
      end

      // the overflow line always goes out ahead of the closing line
      push.first  = advance && (overflow || closes);
      push.second = advance && overflow && closes;
      data_first  = overflow ? {open_ff, last_ff, 1'b0}
                             : {close_begin, pos_ff, close_final};
      data_second = {close_begin, pos_ff, close_final};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= '1;
         in_valid_ff <= 1'b0;
         open_ff     <= '0;
         last_ff     <= '0;
         commit_ff   <= '0;
         pend_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            open_ff   <= open_in;
            last_ff   <= last_in;
            commit_ff <= commit_in;
            pend_ff   <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff  <= req_grapheme_end;
         adv_ff  <= req_advance;
         brk_ff  <= req_break_after;
         mand_ff <= req_mandatory;
         eot_ff  <= req_end_of_text;
      end
   end

   glb_result_queue #(
      .ENTRY_BITS(ENTRY_BITS)
   ) u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_data_first (data_first),
      .push_data_second(data_second),
      .room            (room),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_data        (data_out)
   );

   assign rsp_line_begin  = data_out[ENTRY_BITS-1 -: OFFSET_BITS];
   assign rsp_line_finish = data_out[OFFSET_BITS:1];
   assign rsp_final_line  = data_out[0];

endmodule

// ===== tb/tb_greedy_line_breaker.sv =====
// self-checking testbench of the greedy line breaker with its own line-breaking predictor
module tb_greedy_line_breaker;
   import glb_pkg::*;

   localparam int OB = 16;
   localparam int WB = 48;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS = 330;
   localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

   typedef struct {
      logic [OB-1:0]           grapheme_end;
      logic [ADVANCE_BITS-1:0] advance;
      logic                    break_after;
      logic                    mandatory;
      logic                    end_of_text;
   } grapheme_type;

   typedef struct {
      logic [OB-1:0] line_begin;
      logic [OB-1:0] line_finish;
      logic          final_line;
   } line_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [LIMIT_BITS-1:0]   csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OB-1:0]           req_grapheme_end = '0;
   logic [ADVANCE_BITS-1:0] req_advance = '0;
   logic                    req_break_after = 1'b0;
   logic                    req_mandatory = 1'b0;
   logic                    req_end_of_text = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [OB-1:0]           rsp_line_begin;
   logic [OB-1:0]           rsp_line_finish;
   logic                    rsp_final_line;

   grapheme_type pending_items[$];
   line_type     expected_lines[$];

   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatches = 0;
   int unsigned cycles;
   bit          item_taken = 0;
   bit          line_taken = 0;
   bit          quick_mode = 0;
   bit          sender_calm = 0;
   bit          receiver_calm = 0;
   int unsigned send_wait = 0;
   int unsigned stall_left = 0;

   logic [LIMIT_BITS-1:0] model_limit = LIMIT_MAX;
   logic [OB-1:0]         model_line_start = '0;
   logic [OB-1:0]         model_break_at = '0;
   logic [WB-1:0]         model_committed = '0;
   logic [WB-1:0]         model_unit = '0;

   greedy_line_breaker #(.OFFSET_BITS(OB), .WIDTH_BITS(WB)) DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_grapheme_end(req_grapheme_end),
      .req_advance(req_advance),
      .req_break_after(req_break_after),
      .req_mandatory(req_mandatory),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_begin(rsp_line_begin),
      .rsp_line_finish(rsp_line_finish),
      .rsp_final_line(rsp_final_line)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [WB-1:0] sat_width(input logic [WB-1:0] a, input logic [WB-1:0] b);
      logic [WB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WB] ? '1 : s[WB-1:0];
   endfunction

   function automatic int unsigned draw_pause(inout bit calm);
      if ($urandom_range(0, 24) == 0)
         calm = !calm;
      if (quick_mode || calm)
         return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic expect_line(input logic [OB-1:0] b, input logic [OB-1:0] f, input logic fin);
      line_type entry;
      entry = '{b, f, fin};
      expected_lines = {expected_lines, entry};
   endtask

   task automatic fit_grapheme(input grapheme_type g);
      model_unit = sat_width(model_unit, {{(WB-ADVANCE_BITS){1'b0}}, g.advance});
      if (g.break_after || g.mandatory || g.end_of_text) begin
         if (model_break_at > model_line_start &&
             sat_width(model_committed, model_unit) > {{(WB-LIMIT_BITS){1'b0}}, model_limit}) begin
            expect_line(model_line_start, model_break_at, 1'b0);
            model_line_start = model_break_at;
            model_committed = '0;
         end
         model_committed = sat_width(model_committed, model_unit);
         model_unit = '0;
         model_break_at = g.grapheme_end;
         if (g.mandatory) begin
            expect_line(model_line_start, g.grapheme_end, g.end_of_text);
            model_line_start = g.grapheme_end;
            model_committed = '0;
         end else if (g.end_of_text) begin
            if (model_line_start < g.grapheme_end)
               expect_line(model_line_start, g.grapheme_end, 1'b1);
            else
               expect_line(g.grapheme_end, g.grapheme_end, 1'b1);
         end
         if (g.end_of_text) begin
            model_line_start = '0;
            model_break_at = '0;
            model_committed = '0;
            model_unit = '0;
         end
      end
   endtask

   // monitor: config mirror, line checks and item prediction
   always @(posedge clock) begin
      grapheme_type g;
      line_type want;
      item_taken = 0;
      line_taken = 0;
      if (!reset) begin
         if (csr_wr_en)
            model_limit = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            line_taken = 1;
            if (expected_lines.size() == 0) begin
               report_mismatch($sformatf("line %0d..%0d with none expected",
                                         rsp_line_begin, rsp_line_finish));
            end else begin
               want = expected_lines.pop_front();
               if (rsp_line_begin !== want.line_begin)
                  report_mismatch($sformatf("line_begin %0d, wanted %0d",
                                            rsp_line_begin, want.line_begin));
               if (rsp_line_finish !== want.line_finish)
                  report_mismatch($sformatf("line_finish %0d, wanted %0d",
                                            rsp_line_finish, want.line_finish));
               if (rsp_final_line !== want.final_line)
                  report_mismatch($sformatf("final_line %0b, wanted %0b",
                                            rsp_final_line, want.final_line));
            end
         end
         if (req_valid && !req_stall) begin
            item_taken = 1;
            g = '{req_grapheme_end, req_advance, req_break_after, req_mandatory,
                  req_end_of_text};
            fit_grapheme(g);
            accepted_count++;
         end
      end
   end

   // item driver
   always @(negedge clock) begin
      grapheme_type g;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            g = pending_items.pop_front();
            req_grapheme_end <= g.grapheme_end;
            req_advance <= g.advance;
            req_break_after <= g.break_after;
            req_mandatory <= g.mandatory;
            req_end_of_text <= g.end_of_text;
            req_valid <= 1'b1;
            send_wait = draw_pause(sender_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // line receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (line_taken)
            stall_left = draw_pause(receiver_calm);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   task automatic queue_grapheme(input logic [OB-1:0] pos, input logic [31:0] adv,
                                 input logic brk, input logic mand, input logic eot);
      grapheme_type g;
      g = '{pos, adv, brk, mand, eot};
      pending_items = {pending_items, g};
      queued_count++;
   endtask

   task automatic queue_paragraph(input logic [31:0] adv_cap);
      int unsigned n;
      bit noise;
      logic [OB-1:0] pos;
      logic [31:0] adv;
      logic eot;
      if ($urandom_range(0, 29) == 0) begin
         queue_grapheme('0, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'b1);
         return;
      end
      n = $urandom_range(1, 30);
      noise = ($urandom_range(0, 9) == 0);
      pos = ($urandom_range(0, 7) == 0) ? OB'($urandom) : '0;
      for (int i = 0; i < n; i++) begin
         pos = noise ? OB'($urandom) : pos + OB'($urandom_range(1, 4));
         adv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, adv_cap);
         eot = (i == n - 1) ? (!noise || $urandom_range(0, 1)) :
               (noise && $urandom_range(0, 15) == 0);
         queue_grapheme(pos, adv,
                        noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0),
                        $urandom_range(0, 19) == 0, eot);
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expected_lines.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned phase_start;
      logic [LIMIT_BITS-1:0] new_limit;
      logic [31:0] cap;

      // empty text, mandatory without break chance, consumed final line, forced end
      queue_grapheme(16'd0, 32'd0, 1'b0, 1'b0, 1'b1);
      queue_grapheme(16'd5, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd65535, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
      queue_grapheme(16'd65535, 32'd0, 1'b0, 1'b0, 1'b1);
      queue_grapheme(16'd3, 32'd10, 1'b1, 1'b1, 1'b1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_drained();

      set_limit(31'd1);
      // overflow then mandatory, overflow then end, offsets going back
      queue_grapheme(16'd2, 32'd1, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd4, 32'd1, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd6, 32'd5, 1'b0, 1'b1, 1'b0);
      queue_grapheme(16'd9, 32'd1, 1'b1, 1'b0, 1'b1);
      queue_grapheme(16'd3, 32'd1, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd7, 32'd1, 1'b0, 1'b0, 1'b1);
      queue_grapheme(16'd8, 32'd0, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd4, 32'd0, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd2, 32'd0, 1'b0, 1'b0, 1'b1);
      queue_grapheme(16'd8, 32'd1, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd10, 32'd1, 1'b1, 1'b0, 1'b0);
      queue_grapheme(16'd3, 32'd1, 1'b0, 1'b0, 1'b1);
      wait_drained();

      // short run back to back with no pauses on either side
      set_limit(31'd300);
      quick_mode = 1;
      repeat (3) queue_paragraph(32'd60);
      wait_drained();
      quick_mode = 0;

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: new_limit = 31'd1;
            1: new_limit = LIMIT_BITS'($urandom_range(2, 200));
            2: new_limit = LIMIT_BITS'($urandom_range(200, 20000));
            3: new_limit = LIMIT_BITS'($urandom_range(1, 32'h7FFF_FFFF));
            4: new_limit = LIMIT_MAX;
            default: new_limit = LIMIT_BITS'($urandom_range(20000, 2000000));
         endcase
         set_limit(new_limit);
         cap = {1'b0, new_limit} / 6 + 1;
         phase_start = queued_count;
         while (queued_count - phase_start < PHASE_ITEMS)
            queue_paragraph(cap);
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
